/* design/svpwm_pkg.sv */
// types, constants and helpers for the space vector pwm compare generator
package svpwm_pkg;

	typedef struct packed {
		logic [15:0] amplitude;
		logic [5:0]  angle_incr;
	} req_t;

	typedef struct packed {
		logic [15:0] compare_phase_a;
		logic [15:0] compare_phase_b;
		logic [15:0] compare_phase_c;
		logic [2:0]  sector;
	} res_t;

	localparam logic [2:0]  SECTOR_1 = 3'd1;
	localparam logic [2:0]  SECTOR_2 = 3'd2;
	localparam logic [2:0]  SECTOR_3 = 3'd3;
	localparam logic [2:0]  SECTOR_4 = 3'd4;
	localparam logic [2:0]  SECTOR_5 = 3'd5;
	localparam logic [2:0]  SECTOR_6 = 3'd6;

	localparam logic [15:0] PERIOD_RESET = 16'd1023;

	localparam logic [63:0] Q30_ONE      = 64'd1073741824;
	localparam logic [63:0] Q30_PI_THIRD = 64'd1124419809;
	localparam logic [63:0] Q30_HALF     = 64'd536870912;

	// halve a signed sum, floor at zero and saturate to 16 bits
	function automatic logic [15:0] half_sat(input logic signed [18:0] v);
		logic [17:0] h;
		h = 18'(v >>> 1);
		if (v < 0) begin
			return 16'd0;
		end else if (h > 18'd65535) begin
			return 16'hFFFF;
		end else begin
			return h[15:0];
		end
	endfunction

endpackage

/* design/space_vector_pwm_compare_gen.sv */
// space vector pwm compare generator top level: sector tracking, sine rom, compare values
// datapath: input register, then result register (sine rom, multiply, centering and sector
// routing sit between the two)
// throughput: one request per cycle; the input register holds only while the result is stalled
// reset: angle 0, sector 1, pwm period 1023, both registers empty
module space_vector_pwm_compare_gen #(
	parameter int TABLE_SIZE = 64,
	parameter int MAX_STEP   = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  svpwm_pkg::req_t   req_data,
	output logic              res_valid,
	input  logic              res_stall,
	output svpwm_pkg::res_t   res_data,
	input  logic              cfg_wr_en,
	input  logic [15:0]       cfg_wr_data
);
	import svpwm_pkg::*;

	localparam int LAST_INDEX = TABLE_SIZE - 1;
	localparam int IDX_W      = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1;

	// sine rom, 0 to 60 degrees scaled by 256, built at elaboration
	logic [7:0] sine_rom [TABLE_SIZE];

	for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_rom
		localparam logic [63:0] X  = (Q30_PI_THIRD * 64'(i) + 64'(LAST_INDEX / 2))
			/ 64'(LAST_INDEX);
		localparam logic [63:0] X2 = (X * X) >> 30;
		localparam logic [63:0] T1 = Q30_ONE - X2 / 64'd72;
		localparam logic [63:0] T2 = Q30_ONE - ((X2 * T1) >> 30) / 64'd42;
		localparam logic [63:0] T3 = Q30_ONE - ((X2 * T2) >> 30) / 64'd20;
		localparam logic [63:0] T4 = Q30_ONE - ((X2 * T3) >> 30) / 64'd6;
		localparam logic [63:0] S  = (X * T4) >> 30;
		localparam logic [63:0] R  = (S * 64'd256 + Q30_HALF) >> 30;
		localparam logic [7:0]  E  = (R > 64'd255) ? 8'd255 : 8'(R);
		assign sine_rom[i] = E;
	end

	logic [15:0]      pwm_period_q;
	logic [7:0]       sector_angle_q;
	logic [2:0]       sector_index_q;

	logic             valid_s1;
	logic [15:0]      amp_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [2:0]       sector_s1;

	logic             res_valid_q;
	res_t             res_q;

	logic             ready_out;
	logic             ready_s1;
	logic             req_accept;

	logic [6:0]       step_c;
	logic [7:0]       angle_sum;
	logic [7:0]       angle_next;
	logic [2:0]       sector_next;
	logic [15:0]      amp_c;
	logic [IDX_W-1:0] idx_next;

	logic [23:0]      prod1;
	logic [23:0]      prod2;
	logic [15:0]      tau1;
	logic [15:0]      tau2;

	logic [18:0]      p_ext;
	logic [18:0]      t1_ext;
	logic [18:0]      t2_ext;
	logic [15:0]      v0;
	logic [15:0]      v1a;
	logic [15:0]      v1b;
	logic [15:0]      v2;
	res_t             res_next;

	assign ready_out  = !res_valid_q || !res_stall;
	assign ready_s1   = !valid_s1 || ready_out;
	assign req_stall  = !ready_s1;
	assign req_accept = req_valid && ready_s1;

	// angle advance and sector wrap
	always_comb begin
		step_c = {1'b0, req_data.angle_incr};
		if (step_c > 7'(MAX_STEP)) begin
			step_c = 7'(MAX_STEP);
		end
		angle_sum   = sector_angle_q + {1'b0, step_c};
		angle_next  = angle_sum;
		sector_next = sector_index_q;
		if (angle_sum > 8'(LAST_INDEX)) begin
			angle_next = angle_sum - 8'(LAST_INDEX);
			if (sector_index_q >= SECTOR_6) begin
				sector_next = SECTOR_1;
			end else begin
				sector_next = sector_index_q + 3'd1;
			end
		end
		if (angle_next > 8'(LAST_INDEX)) begin
			idx_next = IDX_W'(LAST_INDEX);
		end else begin
			idx_next = angle_next[IDX_W-1:0];
		end
		amp_c = (req_data.amplitude > pwm_period_q) ? pwm_period_q : req_data.amplitude;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q   <= PERIOD_RESET;
			sector_angle_q <= 8'd0;
			sector_index_q <= SECTOR_1;
		end else begin
			if (cfg_wr_en) begin
				pwm_period_q <= cfg_wr_data;
			end
			if (req_accept) begin
				sector_angle_q <= angle_next;
				sector_index_q <= sector_next;
			end
		end
	end

	// input register: clamped amplitude, table index, sector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			amp_s1    <= amp_c;
			idx_s1    <= idx_next;
			sector_s1 <= sector_next;
		end
	end

	// active times from the sine rom
	assign prod1 = amp_s1 * sine_rom[IDX_W'(LAST_INDEX) - idx_s1];
	assign prod2 = amp_s1 * sine_rom[idx_s1];
	assign tau1  = prod1[23:8];
	assign tau2  = prod2[23:8];

	// centered compare values routed by sector
	always_comb begin
		p_ext  = {3'b000, pwm_period_q};
		t1_ext = {3'b000, tau1};
		t2_ext = {3'b000, tau2};
		v0  = half_sat($signed(p_ext - t1_ext - t2_ext));
		v1a = half_sat($signed(p_ext + t1_ext - t2_ext));
		v1b = half_sat($signed(p_ext - t1_ext + t2_ext));
		v2  = half_sat($signed(p_ext + t1_ext + t2_ext));
		res_next.sector = sector_s1;
		case (sector_s1)
			SECTOR_2: begin
				res_next.compare_phase_a = v1b;
				res_next.compare_phase_b = v0;
				res_next.compare_phase_c = v2;
			end
			SECTOR_3: begin
				res_next.compare_phase_a = v2;
				res_next.compare_phase_b = v0;
				res_next.compare_phase_c = v1a;
			end
			SECTOR_4: begin
				res_next.compare_phase_a = v2;
				res_next.compare_phase_b = v1b;
				res_next.compare_phase_c = v0;
			end
			SECTOR_5: begin
				res_next.compare_phase_a = v1a;
				res_next.compare_phase_b = v2;
				res_next.compare_phase_c = v0;
			end
			SECTOR_6: begin
				res_next.compare_phase_a = v0;
				res_next.compare_phase_b = v2;
				res_next.compare_phase_c = v1b;
			end
			default: begin
				res_next.compare_phase_a = v0;
				res_next.compare_phase_b = v1a;
				res_next.compare_phase_c = v2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ready_out) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_s1) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule
